@@ hw/rtl/qte_pkg.sv @@
package qte_pkg;

  localparam int unsigned QW        = 16;
  localparam int unsigned PW        = 32;
  localparam int unsigned SW        = 35;
  localparam int unsigned CW        = 37;
  localparam int unsigned ZW        = 28;
  localparam int unsigned RW        = 57;
  localparam int unsigned ROOTW     = 29;
  localparam int unsigned TableLen  = 24;

  localparam logic signed [ZW-1:0] HalfPiQ24 = 28'sd26353589;
  localparam logic signed [15:0]   PiQ13     = 16'sd25736;
  localparam logic signed [15:0]   HalfPiQ13 = 16'sd12868;

  typedef struct packed {
    logic signed [CW-1:0] x;
    logic signed [CW-1:0] y;
    logic signed [ZW-1:0] z;
    logic                 zero;
  } lane_t;

  typedef struct packed {
    logic signed [SW-1:0] sr;
    logic signed [SW-1:0] cr;
    logic signed [SW-1:0] sy;
    logic signed [SW-1:0] cy;
    logic signed [SW-1:0] sp;
    logic                 sat;
  } side_t;

  function automatic logic signed [ZW-1:0] atan_q24(input logic [4:0] idx);
    logic signed [ZW-1:0] r;
    case (idx)
      5'd0:    r = 28'sd13176795;
      5'd1:    r = 28'sd7778716;
      5'd2:    r = 28'sd4110060;
      5'd3:    r = 28'sd2086331;
      5'd4:    r = 28'sd1047214;
      5'd5:    r = 28'sd524117;
      5'd6:    r = 28'sd262123;
      5'd7:    r = 28'sd131069;
      5'd8:    r = 28'sd65536;
      5'd9:    r = 28'sd32768;
      5'd10:   r = 28'sd16384;
      5'd11:   r = 28'sd8192;
      5'd12:   r = 28'sd4096;
      5'd13:   r = 28'sd2048;
      5'd14:   r = 28'sd1024;
      5'd15:   r = 28'sd512;
      5'd16:   r = 28'sd256;
      5'd17:   r = 28'sd128;
      5'd18:   r = 28'sd64;
      5'd19:   r = 28'sd32;
      5'd20:   r = 28'sd16;
      5'd21:   r = 28'sd8;
      5'd22:   r = 28'sd4;
      5'd23:   r = 28'sd2;
      default: r = '0;
    endcase
    return r;
  endfunction

  function automatic logic signed [15:0] to_q13(input logic signed [ZW-1:0] a,
                                               input logic signed [15:0] lim);
    logic signed [ZW-1:0] r;
    logic signed [ZW-1:0] l;
    l = ZW'(lim);
    r = (a + ZW'(1024)) >>> 11;
    if (r > l) r = l;
    if (r < -l) r = -l;
    return r[15:0];
  endfunction

endpackage

@@ hw/rtl/qte_sqrt_cell.sv @@
module qte_sqrt_cell #(
  parameter int unsigned K = 0
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            en_i,
  input  logic                            valid_i,
  input  logic [qte_pkg::RW-1:0]          rem_i,
  input  logic [qte_pkg::ROOTW-1:0]       root_i,
  input  qte_pkg::side_t                  side_i,
  output logic                            valid_o,
  output logic [qte_pkg::RW-1:0]          rem_o,
  output logic [qte_pkg::ROOTW-1:0]       root_o,
  output qte_pkg::side_t                  side_o
);
  import qte_pkg::*;

  logic [RW:0]      test;
  logic [RW-1:0]    rem_d;
  logic [ROOTW-1:0] root_d;
  logic             valid_q;
  logic [RW-1:0]    rem_q;
  logic [ROOTW-1:0] root_q;
  side_t            side_q;

  always_comb begin
    test = ((RW+1)'(root_i) << (K + 1)) + ((RW+1)'(1) << (2 * K));
    if ({1'b0, rem_i} >= test) begin
      rem_d  = rem_i - test[RW-1:0];
      root_d = root_i | (ROOTW'(1) << K);
    end else begin
      rem_d  = rem_i;
      root_d = root_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rem_q  <= rem_d;
      root_q <= root_d;
      side_q <= side_i;
    end
  end

  assign valid_o = valid_q;
  assign rem_o   = rem_q;
  assign root_o  = root_q;
  assign side_o  = side_q;

endmodule

@@ hw/rtl/qte_cordic_cell.sv @@
module qte_cordic_cell #(
  parameter int unsigned I = 0
) (
  input  logic           clk_i,
  input  logic           en_i,
  input  qte_pkg::lane_t lane_i,
  output qte_pkg::lane_t lane_o
);
  import qte_pkg::*;

  lane_t lane_d;
  lane_t lane_q;
  logic signed [CW-1:0] xs;
  logic signed [CW-1:0] ys;

  always_comb begin
    xs = lane_i.x >>> I;
    ys = lane_i.y >>> I;
    lane_d.zero = lane_i.zero;
    if (!lane_i.y[CW-1]) begin
      lane_d.x = lane_i.x + ys;
      lane_d.y = lane_i.y - xs;
      lane_d.z = lane_i.z + atan_q24(5'(I));
    end else begin
      lane_d.x = lane_i.x - ys;
      lane_d.y = lane_i.y + xs;
      lane_d.z = lane_i.z - atan_q24(5'(I));
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      lane_q <= lane_d;
    end
  end

  assign lane_o = lane_q;

endmodule

@@ hw/rtl/quaternion_to_euler_angles.sv @@
// Converts one quaternion (Q14) per clock into roll, pitch and yaw (Q13 radians, Z-Y-X).
// The block is fully pipelined and takes a new request every cycle unless the output stalls;
// each request passes through an input register, four product, sum, square and remainder
// stages, a 29-cell square-root chain for the pitch cosine, a quadrant stage, one CORDIC
// cell per step and the output register. A stall on a valid output freezes the whole
// pipeline.
module quaternion_to_euler_angles #(
  parameter int unsigned CORDIC_STEPS = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic signed [15:0] quat_w_i,
  input  logic signed [15:0] quat_x_i,
  input  logic signed [15:0] quat_y_i,
  input  logic signed [15:0] quat_z_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic signed [15:0] roll_angle_o,
  output logic signed [14:0] pitch_angle_o,
  output logic signed [15:0] yaw_angle_o
);
  import qte_pkg::*;

  localparam int unsigned NStep = (CORDIC_STEPS > TableLen) ? TableLen : CORDIC_STEPS;

  logic en;
  logic out_valid_q;

  assign en         = !(out_valid_q && out_stall_i);
  assign in_stall_o = !en;

  logic v0_q, v1_q, v2_q, v3_q, v4_q;
  logic signed [QW-1:0] w_q, x_q, y_q, z_q;
  logic signed [PW-1:0] p_wx_q, p_yz_q, p_xx_q, p_yy_q, p_wy_q, p_zx_q, p_wz_q, p_xy_q,
                        p_zz_q;
  side_t side2_q, side3_q, side4_q;
  side_t side3_d;
  logic [55:0] sq_q;
  logic [RW-1:0] rem4_q;
  logic [27:0] mag;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v0_q <= 1'b0;
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
    end else if (en) begin
      v0_q <= in_valid_i;
      v1_q <= v0_q;
      v2_q <= v1_q;
      v3_q <= v2_q;
      v4_q <= v3_q;
    end
  end

  always_comb begin
    mag = side2_q.sp[SW-1] ? 28'(-side2_q.sp) : side2_q.sp[27:0];
  end

  always_comb begin
    side3_d     = side2_q;
    side3_d.sat = (side2_q.sp >= (SW'(1) <<< 28)) || (side2_q.sp <= -(SW'(1) <<< 28));
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      w_q <= quat_w_i;
      x_q <= quat_x_i;
      y_q <= quat_y_i;
      z_q <= quat_z_i;
      p_wx_q <= w_q * x_q;
      p_yz_q <= y_q * z_q;
      p_xx_q <= x_q * x_q;
      p_yy_q <= y_q * y_q;
      p_wy_q <= w_q * y_q;
      p_zx_q <= z_q * x_q;
      p_wz_q <= w_q * z_q;
      p_xy_q <= x_q * y_q;
      p_zz_q <= z_q * z_q;
      side2_q.sr  <= (SW'(p_wx_q) + SW'(p_yz_q)) <<< 1;
      side2_q.cr  <= (SW'(1) <<< 28) - ((SW'(p_xx_q) + SW'(p_yy_q)) <<< 1);
      side2_q.sp  <= (SW'(p_wy_q) - SW'(p_zx_q)) <<< 1;
      side2_q.sy  <= (SW'(p_wz_q) + SW'(p_xy_q)) <<< 1;
      side2_q.cy  <= (SW'(1) <<< 28) - ((SW'(p_yy_q) + SW'(p_zz_q)) <<< 1);
      side2_q.sat <= 1'b0;
      side3_q     <= side3_d;
      sq_q        <= 56'(mag) * 56'(mag);
      side4_q     <= side3_q;
      rem4_q      <= (RW'(1) << 56) - RW'(sq_q);
    end
  end

  logic             sv   [ROOTW+1];
  logic [RW-1:0]    srem [ROOTW+1];
  logic [ROOTW-1:0] sroot[ROOTW+1];
  side_t            sside[ROOTW+1];

  assign sv[0]    = v4_q;
  assign srem[0]  = rem4_q;
  assign sroot[0] = '0;
  assign sside[0] = side4_q;

  for (genvar k = 0; k < ROOTW; k++) begin : g_sqrt
    qte_sqrt_cell #(.K(ROOTW - 1 - k)) u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .en_i   (en),
      .valid_i(sv[k]),
      .rem_i  (srem[k]),
      .root_i (sroot[k]),
      .side_i (sside[k]),
      .valid_o(sv[k+1]),
      .rem_o  (srem[k+1]),
      .root_o (sroot[k+1]),
      .side_o (sside[k+1])
    );
  end

  lane_t lane_in[3];
  lane_t pre_d  [3];
  lane_t pre_q  [3];
  logic  cv_q   [NStep+1];
  logic  csat_q [NStep+1];
  logic  cneg_q [NStep+1];

  always_comb begin
    lane_in[0].x = CW'(sside[ROOTW].cr);
    lane_in[0].y = CW'(sside[ROOTW].sr);
    lane_in[1].x = CW'({1'b0, sroot[ROOTW]});
    lane_in[1].y = CW'(sside[ROOTW].sp);
    lane_in[2].x = CW'(sside[ROOTW].cy);
    lane_in[2].y = CW'(sside[ROOTW].sy);
    for (int l = 0; l < 3; l++) begin
      lane_in[l].z    = '0;
      lane_in[l].zero = 1'b0;
      pre_d[l]        = lane_in[l];
      pre_d[l].zero   = (lane_in[l].x == '0) && (lane_in[l].y == '0);
      if (lane_in[l].x[CW-1]) begin
        if (!lane_in[l].y[CW-1]) begin
          pre_d[l].x = lane_in[l].y;
          pre_d[l].y = -lane_in[l].x;
          pre_d[l].z = HalfPiQ24;
        end else begin
          pre_d[l].x = -lane_in[l].y;
          pre_d[l].y = lane_in[l].x;
          pre_d[l].z = -HalfPiQ24;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int s = 0; s <= NStep; s++) cv_q[s] <= 1'b0;
    end else if (en) begin
      cv_q[0] <= sv[ROOTW];
      for (int s = 1; s <= NStep; s++) cv_q[s] <= cv_q[s-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      pre_q     <= pre_d;
      csat_q[0] <= sside[ROOTW].sat;
      cneg_q[0] <= sside[ROOTW].sp[SW-1];
      for (int s = 1; s <= NStep; s++) begin
        csat_q[s] <= csat_q[s-1];
        cneg_q[s] <= cneg_q[s-1];
      end
    end
  end

  lane_t chain[3][NStep+1];

  for (genvar l = 0; l < 3; l++) begin : g_lane
    assign chain[l][0] = pre_q[l];
    for (genvar s = 0; s < NStep; s++) begin : g_step
      qte_cordic_cell #(.I(s)) u_cell (
        .clk_i (clk_i),
        .en_i  (en),
        .lane_i(chain[l][s]),
        .lane_o(chain[l][s+1])
      );
    end
  end

  logic signed [15:0] roll_q, yaw_q, pitch_full;
  logic signed [14:0] pitch_q;

  always_comb begin
    if (csat_q[NStep]) begin
      pitch_full = cneg_q[NStep] ? -HalfPiQ13 : HalfPiQ13;
    end else begin
      pitch_full = to_q13(chain[1][NStep].z, HalfPiQ13);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (en) begin
      out_valid_q <= cv_q[NStep];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      roll_q  <= chain[0][NStep].zero ? '0 : to_q13(chain[0][NStep].z, PiQ13);
      yaw_q   <= chain[2][NStep].zero ? '0 : to_q13(chain[2][NStep].z, PiQ13);
      pitch_q <= pitch_full[14:0];
    end
  end

  assign out_valid_o   = out_valid_q;
  assign roll_angle_o  = roll_q;
  assign pitch_angle_o = pitch_q;
  assign yaw_angle_o   = yaw_q;

endmodule
